FILE: rtl/core/range_add_threshold_count_table_macros.svh
// Assertion macros used by the range add / threshold count table controller
`ifndef RANGE_ADD_THRESHOLD_COUNT_TABLE_MACROS_SVH
`define RANGE_ADD_THRESHOLD_COUNT_TABLE_MACROS_SVH

// property checked on every clock edge outside reset
`define RATCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RATCT_ASSERT_NEXT(label, ante, cons, msg) \
    `RATCT_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/core/ratct_pkg.sv
// Shared constants, types and helpers for the range add / threshold count table
`default_nettype none

package ratct_pkg;

    localparam int ENTRIES     = 1024;
    localparam int BLOCK_SHIFT = 5;
    localparam int BLOCK_SIZE  = 1 << BLOCK_SHIFT;
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 10;
    localparam int OPND_W      = 32;
    localparam int COUNT_W     = 11;

    localparam int NUM_BLOCKS = (ENTRIES + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int ADDR_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int POS_W      = ((INDEX_W > ADDR_W) ? INDEX_W : ADDR_W) + 1;
    localparam int CMP_W      = ((VALUE_W > OPND_W) ? VALUE_W : OPND_W) + 1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_COUNT = 2'd2
    } cmd_t;

    typedef struct packed {
        logic load;
        logic write;
        logic step;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic live;
        logic last;
        logic busy;
    } ctl_stat_t;

    function automatic logic [BLK_W-1:0] blk_of(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] t;
        t = pos >> BLOCK_SHIFT;
        return t[BLK_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/range_add_threshold_count_table.sv
// Top level: block-offset range add and threshold count table
//
//  channel | dir | words                                       | handshake
//  in      | in  | command, left_index, right_index, operand   | in_valid / in_stall
//  out     | out | match_count (count commands only)           | out_valid / out_stall
//
// Write: stores one word. Add: updates entries in part blocks one at a time and
// the offset of each whole block covered. Count: one entry memory read per cycle.
// Empty or reversed ranges end without a walk.
// Reset clears block offsets at once; entries hold nothing until written.
// A finished count waits in the output register while the next word is taken.
`default_nettype none

module range_add_threshold_count_table (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           command,
    input  wire logic [ratct_pkg::INDEX_W-1:0]        left_index,
    input  wire logic [ratct_pkg::INDEX_W-1:0]        right_index,
    input  wire logic signed [ratct_pkg::OPND_W-1:0]  operand,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [ratct_pkg::COUNT_W-1:0]             match_count
);

    ratct_pkg::ctl_cmd_t  cmd;
    ratct_pkg::ctl_stat_t st;

    ratct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .st        (st)
    );

    ratct_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .command     (command),
        .left_index  (left_index),
        .right_index (right_index),
        .operand     (operand),
        .match_count (match_count)
    );

endmodule

`default_nettype wire

FILE: rtl/core/ratct_dp.sv
// Datapath: entry memory, block offsets, range walk counter, compare and count
`default_nettype none

module ratct_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ratct_pkg::ctl_cmd_t                  cmd,
    output ratct_pkg::ctl_stat_t                      st,
    input  wire logic [1:0]                           command,
    input  wire logic [ratct_pkg::INDEX_W-1:0]        left_index,
    input  wire logic [ratct_pkg::INDEX_W-1:0]        right_index,
    input  wire logic signed [ratct_pkg::OPND_W-1:0]  operand,
    output logic [ratct_pkg::COUNT_W-1:0]             match_count
);

    logic [ratct_pkg::VALUE_W-1:0] mem [ratct_pkg::ENTRIES];
    logic [ratct_pkg::VALUE_W-1:0] off_reg [ratct_pkg::NUM_BLOCKS];

    ratct_pkg::cmd_t                    cmd_reg;
    logic                               live_reg;
    logic [ratct_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [ratct_pkg::POS_W-1:0]        hi_reg;
    logic [ratct_pkg::BLK_W-1:0]        bl_reg, bh_reg;
    logic signed [ratct_pkg::OPND_W-1:0] opnd_reg;
    logic                               v1_reg, v1_next;
    logic [ratct_pkg::ADDR_W-1:0]       idx1_reg;
    logic [ratct_pkg::BLK_W-1:0]        blk1_reg;
    logic [ratct_pkg::VALUE_W-1:0]      rd_data_reg;
    logic [ratct_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [ratct_pkg::COUNT_W-1:0]      match_count_reg;

    logic [ratct_pkg::POS_W-1:0]        lo_ext, hi_ext, hi_clamp;
    logic                               range_ok, write_ok;
    logic [ratct_pkg::BLK_W-1:0]        pos_blk, off_addr;
    logic                               whole;
    logic [ratct_pkg::VALUE_W-1:0]      opnd_v, off_rd, eff;
    logic signed [ratct_pkg::CMP_W-1:0] eff_x, thr_x;
    logic                               ge;
    logic                               mem_we;
    logic [ratct_pkg::ADDR_W-1:0]       mem_wa;
    logic [ratct_pkg::VALUE_W-1:0]      mem_wd;

    assign lo_ext   = ratct_pkg::POS_W'(left_index);
    assign hi_ext   = ratct_pkg::POS_W'(right_index);
    assign hi_clamp = (hi_ext >= ratct_pkg::POS_W'(ratct_pkg::ENTRIES))
                    ? ratct_pkg::POS_W'(ratct_pkg::ENTRIES - 1) : hi_ext;
    assign write_ok = lo_ext < ratct_pkg::POS_W'(ratct_pkg::ENTRIES);
    assign range_ok = write_ok && (lo_ext <= hi_ext);

    assign opnd_v   = ratct_pkg::VALUE_W'(opnd_reg);
    assign pos_blk  = ratct_pkg::blk_of(pos_reg);
    assign whole    = (cmd_reg == ratct_pkg::CMD_ADD)
                    && (pos_blk != bl_reg) && (pos_blk != bh_reg);
    assign off_addr = (cmd_reg == ratct_pkg::CMD_COUNT) ? blk1_reg : pos_blk;
    assign off_rd   = off_reg[off_addr];

    assign eff   = rd_data_reg + off_rd;
    assign eff_x = ratct_pkg::CMP_W'($signed(eff));
    assign thr_x = ratct_pkg::CMP_W'(opnd_reg);
    assign ge    = eff_x >= thr_x;

    assign st.cmd  = cmd_reg;
    assign st.live = live_reg;
    assign st.last = !whole && (pos_reg == hi_reg);
    assign st.busy = v1_reg;

    assign match_count = match_count_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = pos_reg[ratct_pkg::ADDR_W-1:0];
        mem_wd = opnd_v - off_rd;
        if (cmd.write && live_reg)
        begin
            mem_we = 1'b1;
        end
        else if (v1_reg && (cmd_reg == ratct_pkg::CMD_ADD))
        begin
            mem_we = 1'b1;
            mem_wa = idx1_reg;
            mem_wd = rd_data_reg + opnd_v;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        v1_next  = 1'b0;
        if (cmd.load)
        begin
            pos_next = lo_ext;
        end
        else if (cmd.step)
        begin
            if (whole)
            begin
                pos_next = pos_reg + ratct_pkg::POS_W'(ratct_pkg::BLOCK_SIZE);
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                v1_next  = 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load)
        begin
            count_next = '0;
        end
        else if (v1_reg && (cmd_reg == ratct_pkg::CMD_COUNT))
        begin
            count_next = count_reg + {{(ratct_pkg::COUNT_W-1){1'b0}}, ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            for (int b = 0; b < ratct_pkg::NUM_BLOCKS; b++)
            begin
                off_reg[b] <= '0;
            end
        end
        else
        begin
            v1_reg <= v1_next;
            if (cmd.step && whole)
            begin
                off_reg[pos_blk] <= off_rd + opnd_v;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.step && !whole)
        begin
            rd_data_reg <= mem[pos_reg[ratct_pkg::ADDR_W-1:0]];
            idx1_reg    <= pos_reg[ratct_pkg::ADDR_W-1:0];
            blk1_reg    <= pos_blk;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        count_reg <= count_next;
        if (cmd.load)
        begin
            cmd_reg  <= ratct_pkg::cmd_t'(command);
            live_reg <= (command == ratct_pkg::CMD_WRITE) ? write_ok : range_ok;
            hi_reg   <= hi_clamp;
            bl_reg   <= ratct_pkg::blk_of(lo_ext);
            bh_reg   <= ratct_pkg::blk_of(hi_clamp);
            opnd_reg <= operand;
        end
        if (cmd.load_out)
        begin
            match_count_reg <= count_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ratct_ctrl.sv
// Controller: command sequencing and handshakes for the table
`default_nettype none

`include "range_add_threshold_count_table_macros.svh"

module ratct_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output ratct_pkg::ctl_cmd_t       cmd,
    input  wire ratct_pkg::ctl_stat_t st
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                case (st.cmd)
                    ratct_pkg::CMD_WRITE:
                    begin
                        cmd.write  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    ratct_pkg::CMD_ADD:
                    begin
                        state_next = st.live ? ST_WALK : ST_IDLE;
                    end
                    ratct_pkg::CMD_COUNT:
                    begin
                        state_next = st.live ? ST_WALK : ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (st.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = (st.cmd == ratct_pkg::CMD_COUNT) ? ST_DONE : ST_IDLE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RATCT_ASSERT_NEXT(a_accept_starts, (state_reg == ST_IDLE) && in_valid, state_reg == ST_START, "accepted word did not start")
    `RATCT_ASSERT_NEXT(a_last_drains, (state_reg == ST_WALK) && st.last, state_reg == ST_DRAIN, "walk did not stop at range end")
    `RATCT_ASSERT_NEXT(a_result_shown, (state_reg == ST_DONE) && out_free, out_valid_reg, "count not presented")
    `RATCT_ASSERT(a_pipe_drained, st.busy |-> ((state_reg == ST_WALK) || (state_reg == ST_DRAIN)), "read stage busy outside walk")

endmodule

`default_nettype wire
